// File: hdl/csla_pkg.sv
// Package: widths, constants and register indexes of the stripe log allocator.
`timescale 1ns / 1ps
package csla_pkg;

   localparam int OFFSET_W      = 41;
   localparam int BLOCK_W       = 40;
   localparam int SIZE_W        = 24;
   localparam int KB_W          = 30;
   localparam int BITS_W        = 5;
   localparam int KB_SHIFT      = 10;
   localparam int MAX_BLOCK_BITS = 16;
   localparam int NEED_W        = OFFSET_W + 1;
   localparam int OLD_OFF_W     = BLOCK_W + MAX_BLOCK_BITS;
   localparam int CSR_DATA_W    = KB_W;
   localparam int CSR_INDEX_W   = 1;

   localparam logic [OFFSET_W-1:0] STRIPE_BYTES = OFFSET_W'(1048576);
   localparam logic [KB_W-1:0]     DISK_SIZE_KB_RESET = KB_W'(1048576);
   localparam logic [BITS_W-1:0]   BLOCK_BITS_RESET   = BITS_W'(9);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DISK_SIZE_KB = 1'b0,
      CSR_BLOCK_BITS   = 1'b1
   } csr_index_type;

endpackage

// File: hdl/csla_if.sv
// Interfaces: request and response channels of the stripe log allocator.
`timescale 1ns / 1ps
interface csla_req_if;
   import csla_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [SIZE_W-1:0]   object_size;
   logic [BLOCK_W-1:0]  old_block;

   modport source  (output valid, op, object_size, old_block, input ready);
   modport sink    (input valid, op, object_size, old_block, output ready);
   modport monitor (input valid, ready, op, object_size, old_block);
endinterface

interface csla_rsp_if;
   import csla_pkg::*;
   logic                valid;
   logic                ready;
   logic [BLOCK_W-1:0]  block_number;
   logic                collided;
   logic                stripe_closed;
   logic                wrapped;
   logic [OFFSET_W-1:0] closed_start;
   logic [OFFSET_W-1:0] closed_end;

   modport source  (output valid, block_number, collided, stripe_closed, wrapped,
                    closed_start, closed_end, input ready);
   modport sink    (input valid, block_number, collided, stripe_closed, wrapped,
                    closed_start, closed_end, output ready);
   modport monitor (input valid, ready, block_number, collided, stripe_closed, wrapped,
                    closed_start, closed_end);
endinterface

// File: hdl/cyclic_stripe_log_allocator.sv
// Top level: cyclic stripe log allocator with registered request and response stages.
`timescale 1ns / 1ps
// Hands out disk space as a circular log, one allocation per clock cycle sustained
// while the response sink keeps up. A request transfer lands in an input register; the next
// cycle the allocation logic (a 42-bit add and compare against the disk limit and stripe
// end, a block shift of the old block, and the round-up of the new offset) reads that
// register and the offset and stripe registers, updates them, and loads the response
// register once that register is free. The response register holds a result while
// the sink stalls, and the input register takes one more request meanwhile, so a
// stalled sink costs no throughput once it resumes. There is no memory and no
// clearing pass: the block accepts requests as soon as reset ends. Write disk_size_kb
// and block_bits only while no request is in flight; block_bits above 16 acts as 16.
module cyclic_stripe_log_allocator (
   input  logic                             clock,
   input  logic                             reset,
   csla_req_if.sink                         req_if,
   csla_rsp_if.source                       rsp_if,
   input  logic                             csr_write_enable,
   input  csla_pkg::csr_index_type          csr_index,
   input  logic [csla_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import csla_pkg::*;

   // configuration
   logic [KB_W-1:0]    disk_size_kb_ff;
   logic [BITS_W-1:0]  block_bits_ff;

   // allocator state
   logic [OFFSET_W-1:0] write_offset_ff, write_offset_in;
   logic [OFFSET_W-1:0] stripe_start_ff, stripe_start_in;
   logic [OFFSET_W-1:0] stripe_end_ff, stripe_end_in;

   // input stage
   logic                s1_valid_ff;
   logic                s1_op_ff;
   logic [SIZE_W-1:0]   s1_size_ff;
   logic [BLOCK_W-1:0]  s1_old_block_ff;

   // response stage
   logic                out_valid_ff;
   logic [BLOCK_W-1:0]  out_block_ff, out_block_in;
   logic                out_collided_ff, out_collided_in;
   logic                out_closed_ff, out_closed_in;
   logic                out_wrapped_ff, out_wrapped_in;
   logic [OFFSET_W-1:0] out_cstart_ff, out_cstart_in;
   logic [OFFSET_W-1:0] out_cend_ff, out_cend_in;

   logic out_free;
   logic advance;
   logic req_take;

   // datapath
   logic [BITS_W-1:0]    bb;
   logic [NEED_W-1:0]    need;
   logic [NEED_W-1:0]    limit;
   logic                 do_wrap;
   logic                 do_close;
   logic [OFFSET_W-1:0]  moved_offset;
   logic [OLD_OFF_W-1:0] old_off;
   logic                 hit;
   logic [MAX_BLOCK_BITS-1:0] blk_mask;
   logic [NEED_W-1:0]    round_sum;
   logic [NEED_W-1:0]    rounded;
   logic [OFFSET_W-1:0]  shifted;

   // handshake: advance the input stage whenever the response slot frees up
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign advance      = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign req_take     = req_if.valid && req_if.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         disk_size_kb_ff <= DISK_SIZE_KB_RESET;
         block_bits_ff   <= BLOCK_BITS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISK_SIZE_KB: disk_size_kb_ff <= csr_write_data;
            CSR_BLOCK_BITS:   block_bits_ff   <= csr_write_data[BITS_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff        <= req_if.op;
         s1_size_ff      <= req_if.object_size;
         s1_old_block_ff <= req_if.old_block;
      end
   end

   // allocation logic
   always_comb begin
      bb = (block_bits_ff > BITS_W'(MAX_BLOCK_BITS)) ? BITS_W'(MAX_BLOCK_BITS)
                                                     : block_bits_ff;
      need  = {1'b0, write_offset_ff} + NEED_W'(s1_size_ff);
      limit = NEED_W'({disk_size_kb_ff, {KB_SHIFT{1'b0}}});

      do_wrap  = need > limit;
      do_close = !do_wrap && (need >= {1'b0, stripe_end_ff});

      // move the stripe first; the collision test looks at the new one
      if (do_wrap) begin
         moved_offset    = '0;
         stripe_start_in = '0;
         stripe_end_in   = STRIPE_BYTES;
      end else if (do_close) begin
         moved_offset    = stripe_end_ff;
         stripe_start_in = stripe_end_ff;
         stripe_end_in   = stripe_end_ff + STRIPE_BYTES;
      end else begin
         moved_offset    = write_offset_ff;
         stripe_start_in = stripe_start_ff;
         stripe_end_in   = stripe_end_ff;
      end

      old_off = OLD_OFF_W'(s1_old_block_ff) << bb;
      hit = (old_off >= OLD_OFF_W'(stripe_start_in)) && (old_off < OLD_OFF_W'(stripe_end_in));
      out_collided_in = (do_wrap || do_close) && s1_op_ff && hit;

      // round the new offset up to a block boundary
      blk_mask  = MAX_BLOCK_BITS'((17'd1 << bb) - 17'd1);
      round_sum = {1'b0, moved_offset} + NEED_W'(s1_size_ff) + NEED_W'(blk_mask);
      rounded   = round_sum & ~NEED_W'(blk_mask);
      shifted   = moved_offset >> bb;

      if (out_collided_in) begin
         write_offset_in = moved_offset;
         out_block_in    = '0;
      end else begin
         write_offset_in = rounded[OFFSET_W-1:0];
         out_block_in    = shifted[BLOCK_W-1:0];
      end

      out_closed_in  = do_wrap || do_close;
      out_wrapped_in = do_wrap;
      out_cstart_in  = out_closed_in ? stripe_start_ff : '0;
      if (do_wrap) begin
         out_cend_in = write_offset_ff;
      end else if (do_close) begin
         out_cend_in = stripe_end_ff;
      end else begin
         out_cend_in = '0;
      end
   end

   // state update: commit once per item, when it moves into the response slot
   always_ff @(posedge clock) begin
      if (reset) begin
         write_offset_ff <= '0;
         stripe_start_ff <= '0;
         stripe_end_ff   <= STRIPE_BYTES;
      end else if (advance) begin
         write_offset_ff <= write_offset_in;
         stripe_start_ff <= stripe_start_in;
         stripe_end_ff   <= stripe_end_in;
      end
   end

   // response register: hold while the sink stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_block_ff    <= out_block_in;
         out_collided_ff <= out_collided_in;
         out_closed_ff   <= out_closed_in;
         out_wrapped_ff  <= out_wrapped_in;
         out_cstart_ff   <= out_cstart_in;
         out_cend_ff     <= out_cend_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.block_number  = out_block_ff;
   assign rsp_if.collided      = out_collided_ff;
   assign rsp_if.stripe_closed = out_closed_ff;
   assign rsp_if.wrapped       = out_wrapped_ff;
   assign rsp_if.closed_start  = out_cstart_ff;
   assign rsp_if.closed_end    = out_cend_ff;

endmodule

// File: hdl/csla_checker.sv
// Checker: port-level assertions for the stripe log allocator, bound to the top level.
`timescale 1ns / 1ps
module csla_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [csla_pkg::BLOCK_W-1:0]     rsp_block_number,
   input logic                             rsp_collided,
   input logic                             rsp_stripe_closed,
   input logic                             rsp_wrapped,
   input logic [csla_pkg::OFFSET_W-1:0]    rsp_closed_start,
   input logic [csla_pkg::OFFSET_W-1:0]    rsp_closed_end
);

   // a wrap or a collision only happens together with a stripe close
   a_wrap_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wrapped) |-> rsp_stripe_closed)
      else $error("wrap reported without a stripe close");

   a_collide_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_collided) |-> rsp_stripe_closed)
      else $error("collision reported without a new stripe");

   // no close: closed bounds read zero
   a_bounds_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stripe_closed) |->
         (rsp_closed_start == '0 && rsp_closed_end == '0))
      else $error("closed stripe bounds set without a close");

   // a collided response carries block number zero
   a_collide_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_collided) |-> (rsp_block_number == '0))
      else $error("collided response with nonzero block number");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_block_number) && $stable(rsp_closed_end)))
      else $error("stalled response changed");

endmodule

bind cyclic_stripe_log_allocator csla_checker u_csla_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_block_number  (rsp_if.block_number),
   .rsp_collided      (rsp_if.collided),
   .rsp_stripe_closed (rsp_if.stripe_closed),
   .rsp_wrapped       (rsp_if.wrapped),
   .rsp_closed_start  (rsp_if.closed_start),
   .rsp_closed_end    (rsp_if.closed_end)
);
